// ===== rtl/mcbrm_pkg.sv =====
// Shared types, codes and constants of the bandwidth record merger.
package mcbrm_pkg;

    // Default configuration of the top level
    localparam int DEF_NUM_CONTROLLERS = 4;
    localparam int DEF_QUEUE_DEPTH     = 16;

    localparam int TIME_W  = 64;
    localparam int COUNT_W = 32;
    localparam int FIG_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int DIV_W   = 64;

    localparam logic [FIG_W-1:0]  SAT48       = '1;
    localparam logic [TIME_W-1:0] NONE_POPPED = '1;
    localparam logic [29:0]       NS_PER_S    = 30'd1_000_000_000;

    // Register reset values
    localparam logic [10:0] LINE_BYTES_RESET = 11'd64;
    localparam logic        ALLOW_RESET      = 1'b0;
    localparam logic [2:0]  ACTIVE_RESET     = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_LINE_BYTES = 2'd0;
    localparam logic [1:0] REG_ALLOW      = 2'd1;
    localparam logic [1:0] REG_ACTIVE     = 2'd2;

    // Request codes; the remaining codes act as a query
    localparam logic [2:0] REQ_PUSH_RD  = 3'd0;
    localparam logic [2:0] REQ_PUSH_WR  = 3'd1;
    localparam logic [2:0] REQ_PROC_ONE = 3'd2;
    localparam logic [2:0] REQ_PROC_ALL = 3'd3;

    // Status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_REV   = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;
    localparam logic [2:0] ST_OVF   = 3'd5;
    localparam logic [2:0] ST_NOPOP = 3'd6;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [1:0]         controller;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  end_time;
        logic [COUNT_W-1:0] access_count;
    } req_t;

    typedef struct packed {
        logic [FIG_W-1:0]  read_bandwidth;
        logic [FIG_W-1:0]  write_bandwidth;
        logic [FIG_W-1:0]  read_rate;
        logic [FIG_W-1:0]  write_rate;
        logic              read_invalid;
        logic              write_invalid;
        logic [2:0]        status;
        logic [TIME_W-1:0] last_read_time;
        logic [TIME_W-1:0] last_write_time;
        logic [TIME_W-1:0] last_popped_time;
    } rsp_t;

    // One interval record as held in the queue memories
    typedef struct packed {
        logic [TIME_W-1:0]  t0;
        logic [TIME_W-1:0]  t1;
        logic [COUNT_W-1:0] n;
    } rec_t;

    typedef enum logic [2:0] {
        CK_OK,
        CK_NONE,
        CK_INV,
        CK_REV,
        CK_ZERO
    } ck_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_PROC_CHK,
        S_SCAN,
        S_FRONT,
        S_LOAD,
        S_CHECK,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_POP1,
        S_MADDR,
        S_MCMP,
        S_MPOP,
        S_TAIL,
        S_OUT
    } state_t;

    // Classify a front record
    function automatic ck_t check_rec(input logic empty, input rec_t r);
        if (empty) begin
            return CK_NONE;
        end
        if (r.t0 < r.t1) begin
            return CK_OK;
        end
        if (r.t0 > r.t1) begin
            return CK_REV;
        end
        if (r.n == '0) begin
            return CK_NONE;
        end
        return (r.t0 == '0) ? CK_INV : CK_ZERO;
    endfunction

endpackage

// ===== rtl/mcbrm_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module mcbrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mcbrm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mcbrm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mcbrm_pkg::DIV_W-1:0] num,
    input  logic [mcbrm_pkg::DIV_W-1:0] den,
    output logic                       done,
    output logic [mcbrm_pkg::DIV_W-1:0] quo
);

    import mcbrm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DIV_W:0]   trial;
    logic             ge;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, den};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== rtl/multi_channel_bandwidth_record_merger_core.sv =====
// Top level of the bandwidth record merger: sequencer, queue control and result register.
//
// Per controller the block keeps a read and a write queue of interval records in two
// record memories (one for each direction, QUEUE_DEPTH entries per controller). Requests
// are handled one at a time. Processing one controller loads and checks its front records,
// then runs up to four divisions (bandwidth and rate for each direction), each with
// operand setup, start, 64 quotient bits and done. Processing all runs those divisions
// for each non-empty controller, followed by a scan over the active controllers for the
// smallest front end time, repeated once for every record popped and once more to
// finish. All divisions share the one divider, which yields one quotient bit per cycle. A
// new request is taken while the previous result still waits in the output register.
module multi_channel_bandwidth_record_merger_core #(
    parameter int NUM_CONTROLLERS = mcbrm_pkg::DEF_NUM_CONTROLLERS,
    parameter int QUEUE_DEPTH     = mcbrm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mcbrm_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output mcbrm_pkg::rsp_t   rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [10:0]       cfg_data
);

    import mcbrm_pkg::*;

    localparam int NC    = NUM_CONTROLLERS;
    localparam int QD    = QUEUE_DEPTH;
    localparam int CW    = (NC > 1) ? $clog2(NC) : 1;
    localparam int NAW   = $clog2(NC + 1);
    localparam int HW    = $clog2(QD);
    localparam int FW    = $clog2(QD + 1);
    localparam int DEPTH = NC * QD;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $bits(rec_t);

    state_t state_reg, state_next;

    // Configuration
    logic [10:0] line_bytes_reg;
    logic        allow_reg;
    logic [2:0]  active_reg;

    // Queue control
    logic [HW-1:0]     head_r_reg [NC];
    logic [HW-1:0]     head_w_reg [NC];
    logic [FW-1:0]     fill_r_reg [NC];
    logic [FW-1:0]     fill_w_reg [NC];
    logic [TIME_W-1:0] popped_reg [NC];
    logic [TIME_W-1:0] global_reg;

    // Request context
    logic [2:0]         req_type_reg;
    logic [CW-1:0]      ctl_reg;
    rec_t               push_rec_reg;
    logic [NAW-1:0]     scan_reg;
    rec_t               fr_reg, fw_reg;
    logic               re_reg, we_reg;
    logic               okr_reg, okw_reg;
    logic [2:0]         status_reg;
    logic               rinv_reg, winv_reg, allinv_reg;
    logic [FIG_W-1:0]   acc_reg [4];
    logic [1:0]         div_sel_reg;
    logic [DIV_W-1:0]   num_reg, den_reg;
    logic [TIME_W-1:0]  best_reg;
    logic               found_reg, first_reg, pw_reg;
    logic [CW-1:0]      pc_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    // Memory ports
    logic            rd_we, wr_we;
    logic [AW-1:0]   waddr, rd_raddr, wr_raddr;
    logic [RW-1:0]   rd_rdata, wr_rdata;
    rec_t            rd_rec, wr_rec;
    logic            div_start, div_done;
    logic [DIV_W-1:0] div_quo;

    // Helpers
    logic [7:0]    na8;
    logic [7:0]    ctl8;
    logic [CW-1:0] ctl_sel;
    logic [CW-1:0] c_idx;
    logic          scan_done;
    logic          is_one;
    logic          any_empty;
    logic          proc_empty_err;
    logic          both_empty;
    logic          push_wr;
    logic          push_full;
    ck_t           ckr, ckw;
    logic          chk_err;
    logic          chk_inv_all;
    logic          dir_ok;
    rec_t          div_rec;
    logic [42:0]   prod_bw;
    logic [61:0]   prod_rate;
    logic [FIG_W-1:0] quo_sat;
    logic [FIG_W:0]   acc_sum;
    logic [FIG_W-1:0] acc_new;
    logic [TIME_W-1:0] min_best;
    logic             min_found;
    logic [CW-1:0]    min_pc;
    logic             min_pw;
    logic             mpop_go;
    logic             pop_r1, pop_w1;
    logic             out_free;
    state_t           end_state;
    rsp_t             out_next;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input int s);
        return AW'(int'(c) * QD + s);
    endfunction

    function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
        return (int'(h) == QD - 1) ? '0 : HW'(h + 1'b1);
    endfunction

    function automatic int slot_add(input logic [HW-1:0] h, input logic [FW-1:0] f);
        int s;
        s = int'(h) + int'(f);
        if (s >= QD)
        begin
            s = s - QD;
        end
        return s;
    endfunction

    function automatic int slot_tail(input logic [HW-1:0] h, input logic [FW-1:0] f);
        int s;
        s = int'(h) + int'(f) - 1;
        if (s >= QD)
        begin
            s = s - QD;
        end
        if (s < 0)
        begin
            s = 0;
        end
        return s;
    endfunction

    // Active controller count and addressed controller
    always_comb
    begin
        na8 = {5'b0, active_reg};
        if (na8 == 8'd0)
        begin
            na8 = 8'd1;
        end
        else if (na8 > 8'(NC))
        begin
            na8 = 8'(NC);
        end
        ctl8    = {6'b0, req.controller};
        ctl_sel = (ctl8 >= na8) ? CW'(na8 - 8'd1) : CW'(ctl8);
    end

    assign c_idx     = scan_reg[CW-1:0];
    assign scan_done = 8'(scan_reg) >= na8;
    assign is_one    = req_type_reg == REQ_PROC_ONE;
    assign both_empty = (fill_r_reg[c_idx] == '0) && (fill_w_reg[c_idx] == '0);
    assign push_wr   = req_type_reg == REQ_PUSH_WR;
    assign push_full = push_wr ? (fill_w_reg[ctl_reg] >= FW'(QD))
                               : (fill_r_reg[ctl_reg] >= FW'(QD));
    assign rd_rec    = rec_t'(rd_rdata);
    assign wr_rec    = rec_t'(wr_rdata);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign end_state = is_one ? S_POP1 : S_SCAN;

    // Empty check over active controllers
    always_comb
    begin
        any_empty = 1'b0;
        for (int c = 0; c < NC; c++)
        begin
            if ((8'(c) < na8) && ((fill_r_reg[c] == '0) || (fill_w_reg[c] == '0)))
            begin
                any_empty = 1'b1;
            end
        end
        if (is_one)
        begin
            proc_empty_err = !allow_reg &&
                ((fill_r_reg[ctl_reg] == '0) || (fill_w_reg[ctl_reg] == '0));
        end
        else
        begin
            proc_empty_err = !allow_reg && any_empty;
        end
    end

    // Front record classification
    always_comb
    begin
        ckr = check_rec(re_reg, fr_reg);
        ckw = check_rec(we_reg, fw_reg);
        chk_err = (ckr == CK_REV) || (ckr == CK_ZERO) ||
                  (ckw == CK_REV) || (ckw == CK_ZERO) ||
                  (is_one && re_reg && we_reg);
        chk_inv_all = !is_one && ((ckr == CK_INV) || (ckw == CK_INV));
    end

    // Numerator and divisor of the selected figure
    always_comb
    begin
        dir_ok    = div_sel_reg[1] ? okw_reg : okr_reg;
        div_rec   = div_sel_reg[1] ? fw_reg : fr_reg;
        prod_bw   = 43'(line_bytes_reg) * 43'(div_rec.n);
        prod_rate = 62'(div_rec.n) * 62'(NS_PER_S);
    end

    // Saturate the quotient and add it to its sum
    always_comb
    begin
        quo_sat = (div_quo > DIV_W'(SAT48)) ? SAT48 : div_quo[FIG_W-1:0];
        acc_sum = {1'b0, acc_reg[div_sel_reg]} + {1'b0, quo_sat};
        acc_new = acc_sum[FIG_W] ? SAT48 : acc_sum[FIG_W-1:0];
    end

    // Running minimum over the queue fronts
    always_comb
    begin
        min_best  = best_reg;
        min_found = found_reg;
        min_pc    = pc_reg;
        min_pw    = pw_reg;
        if ((fill_r_reg[c_idx] != '0) && (rd_rec.t1 < min_best))
        begin
            min_best  = rd_rec.t1;
            min_found = 1'b1;
            min_pc    = c_idx;
            min_pw    = 1'b0;
        end
        if ((fill_w_reg[c_idx] != '0) && (wr_rec.t1 < min_best))
        begin
            min_best  = wr_rec.t1;
            min_found = 1'b1;
            min_pc    = c_idx;
            min_pw    = 1'b1;
        end
        mpop_go = found_reg && (first_reg || (best_reg <= global_reg));
    end

    // Pop decision of a single controller
    assign pop_r1 = !re_reg && (we_reg || (fr_reg.t1 <= fw_reg.t1));
    assign pop_w1 = !we_reg && (re_reg || (fw_reg.t1 <= fr_reg.t1));

    // Result beat
    always_comb
    begin
        out_next.read_bandwidth   = (status_reg != ST_OK || allinv_reg) ? '0 : acc_reg[0];
        out_next.read_rate        = (status_reg != ST_OK) ? '0 : acc_reg[1];
        out_next.write_bandwidth  = (status_reg != ST_OK || allinv_reg) ? '0 : acc_reg[2];
        out_next.write_rate       = (status_reg != ST_OK) ? '0 : acc_reg[3];
        out_next.read_invalid     = rinv_reg;
        out_next.write_invalid    = winv_reg;
        out_next.status           = status_reg;
        out_next.last_popped_time = global_reg;
        if (fill_r_reg[ctl_reg] != '0)
        begin
            out_next.last_read_time = rd_rec.t1;
        end
        else
        begin
            out_next.last_read_time =
                (popped_reg[ctl_reg] == NONE_POPPED) ? '0 : popped_reg[ctl_reg];
        end
        if (fill_w_reg[ctl_reg] != '0)
        begin
            out_next.last_write_time = wr_rec.t1;
        end
        else
        begin
            out_next.last_write_time =
                (popped_reg[ctl_reg] == NONE_POPPED) ? '0 : popped_reg[ctl_reg];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.req_type inside {REQ_PUSH_RD, REQ_PUSH_WR})
                    begin
                        state_next = S_PUSH;
                    end
                    else if (req.req_type inside {REQ_PROC_ONE, REQ_PROC_ALL})
                    begin
                        state_next = S_PROC_CHK;
                    end
                    else
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_PUSH:     state_next = S_TAIL;
            S_PROC_CHK:
            begin
                if (proc_empty_err)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    state_next = is_one ? S_FRONT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_MADDR;
                end
                else if (!both_empty)
                begin
                    state_next = S_FRONT;
                end
            end
            S_FRONT:    state_next = S_LOAD;
            S_LOAD:     state_next = S_CHECK;
            S_CHECK:
            begin
                if (chk_err)
                begin
                    state_next = S_TAIL;
                end
                else if (chk_inv_all)
                begin
                    state_next = S_MADDR;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (dir_ok)
                begin
                    state_next = S_DSTART;
                end
                else if (div_sel_reg == 2'd3)
                begin
                    state_next = end_state;
                end
            end
            S_DSTART:   state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (div_sel_reg == 2'd3) ? end_state : S_MUL;
                end
            end
            S_POP1:     state_next = S_TAIL;
            S_MADDR:
            begin
                if (scan_done)
                begin
                    state_next = mpop_go ? S_MPOP : S_TAIL;
                end
                else
                begin
                    state_next = S_MCMP;
                end
            end
            S_MCMP:     state_next = S_MADDR;
            S_MPOP:     state_next = S_MADDR;
            S_TAIL:     state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory, divider and handshake controls
    always_comb
    begin
        req_stall = state_reg != S_IDLE;
        div_start = state_reg == S_DSTART;
        rd_we     = (state_reg == S_PUSH) && !push_wr && !push_full;
        wr_we     = (state_reg == S_PUSH) && push_wr && !push_full;
        waddr     = push_wr ? addr_of(ctl_reg, slot_add(head_w_reg[ctl_reg], fill_w_reg[ctl_reg]))
                            : addr_of(ctl_reg, slot_add(head_r_reg[ctl_reg], fill_r_reg[ctl_reg]));
        case (state_reg)
            S_TAIL, S_OUT:
            begin
                rd_raddr = addr_of(ctl_reg, slot_tail(head_r_reg[ctl_reg], fill_r_reg[ctl_reg]));
                wr_raddr = addr_of(ctl_reg, slot_tail(head_w_reg[ctl_reg], fill_w_reg[ctl_reg]));
            end
            default:
            begin
                rd_raddr = addr_of(c_idx, int'(head_r_reg[c_idx]));
                wr_raddr = addr_of(c_idx, int'(head_w_reg[c_idx]));
            end
        endcase
    end

    // Control state: sequencer, configuration, queue pointers, popped times
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            line_bytes_reg <= LINE_BYTES_RESET;
            allow_reg      <= ALLOW_RESET;
            active_reg     <= ACTIVE_RESET;
            global_reg     <= NONE_POPPED;
            for (int c = 0; c < NC; c++)
            begin
                head_r_reg[c] <= '0;
                head_w_reg[c] <= '0;
                fill_r_reg[c] <= '0;
                fill_w_reg[c] <= '0;
                popped_reg[c] <= NONE_POPPED;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Hold the result until the beat is taken
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LINE_BYTES: line_bytes_reg <= cfg_data;
                    REG_ALLOW:      allow_reg      <= cfg_data[0];
                    REG_ACTIVE:     active_reg     <= cfg_data[2:0];
                    default:        ;
                endcase
            end

            case (state_reg)
                S_PUSH:
                begin
                    if (!push_full)
                    begin
                        if (push_wr)
                        begin
                            fill_w_reg[ctl_reg] <= fill_w_reg[ctl_reg] + 1'b1;
                        end
                        else
                        begin
                            fill_r_reg[ctl_reg] <= fill_r_reg[ctl_reg] + 1'b1;
                        end
                    end
                end
                S_POP1:
                begin
                    if (pop_r1)
                    begin
                        head_r_reg[ctl_reg] <= head_inc(head_r_reg[ctl_reg]);
                        fill_r_reg[ctl_reg] <= fill_r_reg[ctl_reg] - 1'b1;
                    end
                    if (pop_w1)
                    begin
                        head_w_reg[ctl_reg] <= head_inc(head_w_reg[ctl_reg]);
                        fill_w_reg[ctl_reg] <= fill_w_reg[ctl_reg] - 1'b1;
                    end
                    popped_reg[ctl_reg] <= pop_r1 ? fr_reg.t1 : fw_reg.t1;
                    global_reg          <= pop_r1 ? fr_reg.t1 : fw_reg.t1;
                end
                S_MPOP:
                begin
                    if (pw_reg)
                    begin
                        head_w_reg[pc_reg] <= head_inc(head_w_reg[pc_reg]);
                        fill_w_reg[pc_reg] <= fill_w_reg[pc_reg] - 1'b1;
                    end
                    else
                    begin
                        head_r_reg[pc_reg] <= head_inc(head_r_reg[pc_reg]);
                        fill_r_reg[pc_reg] <= fill_r_reg[pc_reg] - 1'b1;
                    end
                    popped_reg[pc_reg] <= best_reg;
                    global_reg         <= best_reg;
                end
                default: ;
            endcase
        end
    end

    // Request context and figure datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_type_reg    <= req.req_type;
                    ctl_reg         <= ctl_sel;
                    push_rec_reg.t0 <= req.start_time;
                    push_rec_reg.t1 <= req.end_time;
                    push_rec_reg.n  <= req.access_count;
                    status_reg      <= ST_OK;
                    rinv_reg        <= 1'b0;
                    winv_reg        <= 1'b0;
                    allinv_reg      <= 1'b0;
                    for (int i = 0; i < 4; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                end
            end
            S_PUSH:
            begin
                if (push_full)
                begin
                    status_reg <= ST_OVF;
                end
            end
            S_PROC_CHK:
            begin
                if (proc_empty_err)
                begin
                    status_reg <= ST_EMPTY;
                end
                scan_reg <= is_one ? NAW'(ctl_reg) : '0;
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    scan_reg  <= '0;
                    best_reg  <= NONE_POPPED;
                    found_reg <= 1'b0;
                    first_reg <= 1'b1;
                end
                else if (both_empty)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            S_LOAD:
            begin
                fr_reg <= rd_rec;
                fw_reg <= wr_rec;
                re_reg <= fill_r_reg[c_idx] == '0;
                we_reg <= fill_w_reg[c_idx] == '0;
            end
            S_CHECK:
            begin
                okr_reg     <= ckr == CK_OK;
                okw_reg     <= ckw == CK_OK;
                div_sel_reg <= 2'd0;
                if ((ckr == CK_REV) || (ckr == CK_ZERO))
                begin
                    status_reg <= (ckr == CK_REV) ? ST_REV : ST_ZERO;
                end
                else if ((ckw == CK_REV) || (ckw == CK_ZERO))
                begin
                    status_reg <= (ckw == CK_REV) ? ST_REV : ST_ZERO;
                end
                else if (is_one && re_reg && we_reg)
                begin
                    status_reg <= ST_NOPOP;
                end
                else if (chk_inv_all)
                begin
                    allinv_reg <= 1'b1;
                    rinv_reg   <= 1'b1;
                    winv_reg   <= 1'b1;
                    scan_reg   <= '0;
                    best_reg   <= NONE_POPPED;
                    found_reg  <= 1'b0;
                    first_reg  <= 1'b1;
                end
                else if (is_one)
                begin
                    rinv_reg <= ckr == CK_INV;
                    winv_reg <= ckw == CK_INV;
                end
            end
            S_MUL:
            begin
                if (dir_ok)
                begin
                    num_reg <= div_sel_reg[0] ? {2'b0, prod_rate}
                                              : {5'b0, prod_bw, {FRAC_W{1'b0}}};
                    den_reg <= div_rec.t1 - div_rec.t0;
                end
                else if (div_sel_reg != 2'd3)
                begin
                    div_sel_reg <= div_sel_reg + 1'b1;
                end
                else if (!is_one)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    acc_reg[div_sel_reg] <= acc_new;
                    if (div_sel_reg != 2'd3)
                    begin
                        div_sel_reg <= div_sel_reg + 1'b1;
                    end
                    else if (!is_one)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
            end
            S_MCMP:
            begin
                best_reg  <= min_best;
                found_reg <= min_found;
                pc_reg    <= min_pc;
                pw_reg    <= min_pw;
                scan_reg  <= scan_reg + 1'b1;
            end
            S_MPOP:
            begin
                scan_reg  <= '0;
                best_reg  <= NONE_POPPED;
                found_reg <= 1'b0;
                first_reg <= 1'b0;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_reg <= out_next;
                end
            end
            default: ;
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    mcbrm_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_rd_ram (
        .clk   (clk),
        .we    (rd_we),
        .waddr (waddr),
        .wdata (push_rec_reg),
        .raddr (rd_raddr),
        .rdata (rd_rdata)
    );

    mcbrm_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_wr_ram (
        .clk   (clk),
        .we    (wr_we),
        .waddr (waddr),
        .wdata (push_rec_reg),
        .raddr (wr_raddr),
        .rdata (wr_rdata)
    );

    mcbrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // An accepted request keeps the input stalled on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while the sequencer was not left idle");

    // The divider only finishes while a figure is awaited
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DWAIT))
        else $error("divider finished outside its wait state");

    // A pop from the global scan never hits an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MPOP) |-> (pw_reg ? (fill_w_reg[pc_reg] != '0)
                                          : (fill_r_reg[pc_reg] != '0)))
        else $error("pop selected an empty queue");

    // Results with an error status carry zero read bandwidth and zero write rate
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |->
            ((rsp.read_bandwidth == '0) && (rsp.write_rate == '0)))
        else $error("error result carries figures");

endmodule
